FILE: rtl/core/arb_pkg.sv
package arb_pkg;

  localparam int RING_DEPTH_DEF = 1024;
  localparam int MAX_BURST_DEF  = 64;

  localparam int CMD_W    = 3;
  localparam int SAMPLE_W = 32;
  localparam int COUNT_W  = 7;
  localparam int PTRV_W   = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE     = 3'd0,
    CMD_PEEK      = 3'd1,
    CMD_ADVANCE   = 3'd2,
    CMD_SET_READ  = 3'd3,
    CMD_SET_WRITE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BURST,
    ST_REPLY
  } state_t;

endpackage

FILE: rtl/core/arb_sample_ram.sv
module arb_sample_ram #(
  parameter int DEPTH = arb_pkg::RING_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [arb_pkg::SAMPLE_W-1:0]  wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [arb_pkg::SAMPLE_W-1:0]  rdata
);
  import arb_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data between reads so a stalled word stays put
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/audio_ring_buffer_peek_advance.sv
// Write and set commands: accepted every cycle while idle, no result word.
// Peek: registered into the burst state, then words come from the sample memory
// read port, one word per cycle while the output is not stalled.
// Advance, refusal and zero-frame requests: one word, via the reply state.
// Input stalls while a peek or advance response is being delivered.
// Reset clears both pointers; sample memory contents stay undefined, no clear pass.
module audio_ring_buffer_peek_advance #(
  parameter int RING_DEPTH = arb_pkg::RING_DEPTH_DEF,
  parameter int MAX_BURST  = arb_pkg::MAX_BURST_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [arb_pkg::CMD_W-1:0]     command,
  input  logic [arb_pkg::SAMPLE_W-1:0]  sample_in,
  input  logic [arb_pkg::COUNT_W-1:0]   frame_count,
  input  logic [arb_pkg::PTRV_W-1:0]    pointer_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [arb_pkg::SAMPLE_W-1:0]  sample_out,
  output logic [arb_pkg::COUNT_W-1:0]   granted,
  output logic                          last
);
  import arb_pkg::*;

  localparam int PW = $clog2(RING_DEPTH);
  localparam logic [PW:0] DEPTH_W = (PW+1)'(RING_DEPTH);

  state_t state, state_next;

  logic [PW-1:0] read_pointer, write_pointer;
  logic [PW-1:0] rd_addr;
  logic [COUNT_W-1:0] remaining;
  logic [COUNT_W-1:0] reply_grant;
  logic from_mem;
  logic [SAMPLE_W-1:0] mem_q;

  logic accept;
  logic can_load;
  logic rd_en;
  logic mem_we;
  logic req_ok;
  logic [PW:0] diff;
  logic [PW-1:0] avail;
  logic [PW:0] adv_sum;
  logic [PW-1:0] adv_pointer;
  logic [PW-1:0] wp_inc;
  logic [PW-1:0] addr_inc;
  logic [PTRV_W-1:0] ptr_red;
  logic [PW-1:0] set_pointer;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign can_load = !out_valid || !out_stall;
  assign mem_we   = accept && (command == CMD_WRITE);
  assign rd_en    = (state == ST_BURST) && can_load;

  // availability wraps, so a full ring reads as empty
  always_comb begin
    diff = {1'b0, write_pointer} - {1'b0, read_pointer};
    if (diff[PW]) begin
      diff = diff + DEPTH_W;
    end
    avail = diff[PW-1:0];
  end

  assign req_ok = (frame_count != '0) && (int'(frame_count) <= MAX_BURST) &&
                  (int'(avail) >= int'(frame_count));

  // granted count is below depth, so one wrap suffices
  always_comb begin
    adv_sum = {1'b0, read_pointer} + (PW+1)'(frame_count);
    if (adv_sum >= DEPTH_W) begin
      adv_sum = adv_sum - DEPTH_W;
    end
    adv_pointer = adv_sum[PW-1:0];
  end

  assign wp_inc   = ({1'b0, write_pointer} + 1'b1 == DEPTH_W) ? '0 : write_pointer + 1'b1;
  assign addr_inc = ({1'b0, rd_addr} + 1'b1 == DEPTH_W) ? '0 : rd_addr + 1'b1;

  // reduce pointer_value mod depth by shifted compare and subtract
  always_comb begin
    int step;
    ptr_red = pointer_value;
    for (int k = PTRV_W - 1; k >= 0; k--) begin
      step = RING_DEPTH << k;
      if (int'(ptr_red) >= step) begin
        ptr_red = ptr_red - PTRV_W'(step);
      end
    end
    set_pointer = PW'(ptr_red);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && command == CMD_PEEK) begin
          state_next = req_ok ? ST_BURST : ST_REPLY;
        end else if (accept && command == CMD_ADVANCE) begin
          state_next = ST_REPLY;
        end
      end
      ST_BURST: begin
        if (can_load && remaining == COUNT_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_REPLY: begin
        if (can_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer  <= '0;
      write_pointer <= '0;
    end else if (accept) begin
      case (command)
        CMD_WRITE:     write_pointer <= wp_inc;
        CMD_ADVANCE:   if (req_ok) read_pointer <= adv_pointer;
        CMD_SET_READ:  read_pointer  <= set_pointer;
        CMD_SET_WRITE: write_pointer <= set_pointer;
        default: ;
      endcase
    end
  end

  // latch the request for the response phase; every word of a burst
  // carries the full frame count
  always_ff @(posedge clk) begin
    if (accept && (command == CMD_PEEK || command == CMD_ADVANCE)) begin
      rd_addr     <= read_pointer;
      remaining   <= frame_count;
      reply_grant <= req_ok ? frame_count : '0;
    end else if (rd_en) begin
      rd_addr   <= addr_inc;
      remaining <= remaining - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= (state == ST_BURST) || (state == ST_REPLY);
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && state == ST_BURST) begin
      from_mem <= 1'b1;
      granted  <= reply_grant;
      last     <= (remaining == COUNT_W'(1));
    end else if (can_load && state == ST_REPLY) begin
      from_mem <= 1'b0;
      granted  <= reply_grant;
      last     <= 1'b1;
    end
  end

  assign sample_out = from_mem ? mem_q : '0;

  arb_sample_ram #(
    .DEPTH (RING_DEPTH),
    .AW    (PW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (write_pointer),
    .wdata (sample_in),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (mem_q)
  );

  a_read_only_in_burst: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (state == ST_BURST))
    else $error("sample read outside a burst");

  a_burst_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BURST && can_load && remaining == COUNT_W'(1)) |=>
      (state == ST_IDLE && out_valid && last))
    else $error("burst did not close with a final word");

  a_pointers_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |=> ($stable(read_pointer) && $stable(write_pointer)))
    else $error("pointer moved during a response");

  a_nonlast_in_burst: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (state == ST_BURST))
    else $error("non-final word with no burst running");

endmodule
